### rtl/oli_pkg.sv
`default_nettype none

package oli_pkg;

	localparam int unsigned POS_W  = 5;
	localparam int unsigned WORD_W = 32;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_PREPEND = 3'd1,
		OP_INSERT  = 3'd2,
		OP_REMOVE  = 3'd3,
		OP_DELETE  = 3'd4,
		OP_READ    = 3'd5
	} oli_kind_e;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} oli_status_e;

	typedef struct packed {
		logic [2:0]        kind;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] entry_value;
	} oli_req_t;

	typedef struct packed {
		oli_status_e       status;
		logic [WORD_W-1:0] read_value;
		logic [POS_W-1:0]  entry_count;
	} oli_rsp_t;

	// Broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
	} oli_cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/oli_cell.sv
`default_nettype none

module oli_cell
	import oli_pkg::*;
#(
	parameter int unsigned CNT_W = 5,
	parameter int unsigned INDEX = 0
) (
	input  wire logic              clk,
	input  wire oli_cell_ctrl_t    ctrl,
	input  wire logic [CNT_W-1:0]  pos,
	input  wire logic [WORD_W-1:0] fill,
	input  wire logic [WORD_W-1:0] left,
	input  wire logic [WORD_W-1:0] right,
	output logic      [WORD_W-1:0] data
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [WORD_W-1:0] data_q;

	// Insert: cells above the slot take their lower neighbour, the slot takes the new word.
	// Delete: the slot and everything above take their upper neighbour.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX > pos) begin
				data_q <= left;
			end else if (MY_IDX == pos) begin
				data_q <= fill;
			end
		end else if (ctrl.del) begin
			if (MY_IDX >= pos) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

### rtl/ordered_list_insert_delete_unit.sv
// Ordered list of up to DEPTH 32-bit words with positional edits.
//
// Channels: req (valid/ready) carries one operation beat: kind, position and
// entry_value. rsp (valid/ready) carries one result beat per operation:
// status, read_value and the entry count after the operation.
//
// Storage is a row of DEPTH cells, one word each. An insert moves every cell
// above the slot up by one place and a delete moves them down, all cells in
// the same clock, together with the count register.
// The result beat is registered and appears in the cycle after the request beat.
// Throughput: one operation per cycle while rsp is not held off, set by the
// single count register and the cell row updating together; the output
// register lets a new beat enter while the previous result is still being taken.
//
// Stall: while rsp is held off, the result stays in the output register and
// req_ready falls, so no further beat is taken until the result leaves.
// Reset: the count clears to zero and no result is pending; the cell words
// are not cleared, since a word is only read after it has been written.

`default_nettype none

module ordered_list_insert_delete_unit
	import oli_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire oli_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output oli_rsp_t      rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	oli_rsp_t          rsp_q;

	logic              accept;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cnt_w;
	logic              full;
	oli_cell_ctrl_t    cell_ctrl;
	logic              do_ins;
	logic              do_del;
	logic [CNT_W-1:0]  cell_pos;
	logic [CNT_W-1:0]  count_nxt;
	oli_status_e       status;
	logic [WORD_W-1:0] rd_word;
	logic [CMP_W-1:0]  count_nxt_w;

	logic [WORD_W-1:0] cell_data [DEPTH];

	// Take a beat whenever the output register is empty or being emptied
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign pos_w = CMP_W'(req.position);
	assign cnt_w = CMP_W'(count_q);
	assign full  = (count_q == FULL_CNT);

	// Decode the operation against the current count
	always_comb begin
		status    = ST_DONE;
		rd_word   = '0;
		do_ins    = 1'b0;
		do_del    = 1'b0;
		cell_pos  = count_q;
		count_nxt = count_q;
		unique case (req.kind)
			OP_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_ins    = 1'b1;
					cell_pos  = count_q;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_PREPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_ins    = 1'b1;
					cell_pos  = '0;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_INSERT: begin
				if (pos_w > cnt_w) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_ins    = 1'b1;
					cell_pos  = pos_w[CNT_W-1:0];
					count_nxt = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				// Drop the top word by shrinking the count; no cell moves
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			OP_DELETE: begin
				if (pos_w >= cnt_w) begin
					status = ST_RANGE;
				end else begin
					do_del    = 1'b1;
					cell_pos  = pos_w[CNT_W-1:0];
					count_nxt = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (pos_w >= cnt_w) begin
					status = ST_RANGE;
				end else begin
					rd_word = cell_data[pos_w[IDX_W-1:0]];
				end
			end
			default: begin
				// Unknown kinds leave the list alone and report done
			end
		endcase
	end

	assign cell_ctrl.ins = accept && do_ins;
	assign cell_ctrl.del = accept && do_del;
	assign count_nxt_w   = CMP_W'(count_nxt);

	// Row of cells; each sees its neighbours, the ends the new word or itself
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = req.entry_value;
		end else begin : g_mid_lo
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_hi
			assign right_w = cell_data[i+1];
		end

		oli_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.ctrl  (cell_ctrl),
			.pos   (cell_pos),
			.fill  (req.entry_value),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	// Count and result handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled, load on each accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= status;
			rsp_q.read_value  <= rd_word;
			rsp_q.entry_count <= count_nxt_w[POS_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### rtl/oli_checker.sv
`default_nettype none

module oli_checker
	import oli_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     rsp_valid,
	input wire logic     rsp_ready,
	input wire oli_rsp_t rsp
);

	localparam bit CNT_FITS = (DEPTH < 32);

	// No result may be pending in the cycle after a reset edge
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result pending after reset");

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// Only a successful operation may carry a read word
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |-> (rsp.read_value == '0))
		else $error("read word on a rejected operation");

	// A full rejection reports a full list (checked only for DEPTH below 32), an empty one an empty list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) && CNT_FITS |->
		(rsp.entry_count == POS_W'(DEPTH)))
		else $error("full status with count below capacity");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0))
		else $error("empty status with entries held");

endmodule

bind ordered_list_insert_delete_unit oli_checker #(.DEPTH(DEPTH)) u_oli_checker (.*);

`default_nettype wire
